// ===== rtl/masked_signature_stream_matcher_defines.svh =====
// Assertion helpers for the matcher back end (msm_back). Expect clk and rst_n in scope.
`ifndef MASKED_SIGNATURE_STREAM_MATCHER_DEFINES_SVH
`define MASKED_SIGNATURE_STREAM_MATCHER_DEFINES_SVH

// same-cycle implication
`define MSM_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) else $error(msg);

// next-cycle implication
`define MSM_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);

`endif

// ===== rtl/msm_pkg.sv =====
package msm_pkg;

  localparam int WINDOW_BYTES_DEF  = 64;
  localparam int POSITION_BITS_DEF = 32;
  localparam int QUEUE_DEPTH       = 4;

  localparam int FUNC_W    = 2;
  localparam int IDX_W     = 6;
  localparam int BYTE_W    = 8;
  localparam int LEN_W     = 7;
  localparam int SHIFT_W   = 7;
  localparam int CNT_W     = 4;
  localparam int POS_OUT_W = 32;
  localparam int REG_IDX_W = 2;

  localparam int IN_TDATA_W  = 24;
  localparam int IN_TUSER_W  = 2;
  localparam int OUT_TDATA_W = 40;
  localparam int OUT_TUSER_W = 2;

  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_DATA = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_EOS  = 2'd2;

  localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_BASE_SHIFT     = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_MAX_MATCHES    = 2'd2;

  typedef enum logic [1:0] {
    CMD_LOAD = 2'd0,
    CMD_DATA = 2'd1,
    CMD_EOS  = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] value;  // pattern byte for a load, stream byte for data
    logic              care;
  } cmd_t;

  typedef struct packed {
    logic [LEN_W-1:0]   pattern_length;
    logic [SHIFT_W-1:0] base_shift;
    logic [CNT_W-1:0]   max_matches;
  } cfg_t;

  typedef struct packed {
    logic                 match_found;
    logic [POS_OUT_W-1:0] match_position;
    logic [CNT_W-1:0]     match_number;
    logic                 stream_done;
    logic [CNT_W-1:0]     match_count;
  } res_t;

endpackage

// ===== rtl/msm_ram.sv =====
module msm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata <= mem_r[raddr];
  end

endmodule

// ===== rtl/msm_front.sv =====
module msm_front import msm_pkg::*; #(
  parameter int WINDOW_BYTES = WINDOW_BYTES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [FUNC_W-1:0] in_func,
  input  logic [IDX_W-1:0]  in_pattern_index,
  input  logic [BYTE_W-1:0] in_pattern_byte,
  input  logic              in_pattern_care,
  input  logic [BYTE_W-1:0] in_data_byte,
  output logic              push_valid,
  input  logic              push_ready,
  output cmd_t              push_cmd
);

  localparam int CW = ((IDX_W > 9) ? IDX_W : 9) + 1;

  logic f_v_r;
  cmd_t f_cmd_r;
  cmd_t cmd_nxt;
  logic keep;

  assign in_ready   = !f_v_r || push_ready;
  assign push_valid = f_v_r;
  assign push_cmd   = f_cmd_r;

  // unused func codes and loads past the window are dropped here
  always_comb begin
    cmd_nxt.idx   = in_pattern_index;
    cmd_nxt.care  = in_pattern_care;
    cmd_nxt.value = in_data_byte;
    cmd_nxt.kind  = CMD_DATA;
    keep          = 1'b0;
    unique case (in_func)
      FUNC_LOAD: begin
        cmd_nxt.kind  = CMD_LOAD;
        cmd_nxt.value = in_pattern_byte;
        keep          = CW'(in_pattern_index) < CW'(WINDOW_BYTES);
      end
      FUNC_DATA: begin
        cmd_nxt.kind = CMD_DATA;
        keep         = 1'b1;
      end
      FUNC_EOS: begin
        cmd_nxt.kind = CMD_EOS;
        keep         = 1'b1;
      end
      default: keep = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_v_r <= 1'b0;
    end else if (in_ready) begin
      f_v_r <= in_valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready) begin
      f_cmd_r <= cmd_nxt;
    end
  end

endmodule

// ===== rtl/msm_queue.sv =====
module msm_queue import msm_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop,
  output cmd_t pop_cmd
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  cmd_t          mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [CW-1:0] cnt_r;
  logic          push;

  assign push_ready = cnt_r != CW'(DEPTH);
  assign pop_valid  = cnt_r != '0;
  assign pop_cmd    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== rtl/msm_back.sv =====
`include "masked_signature_stream_matcher_defines.svh"

module msm_back import msm_pkg::*; #(
  parameter int WINDOW_BYTES  = WINDOW_BYTES_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [REG_IDX_W-1:0] cfg_index,
  input  logic [LEN_W-1:0]     cfg_data,
  input  logic                 q_valid,
  input  cmd_t                 q_cmd,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output res_t                 out_res
);

  localparam int AW = $clog2(WINDOW_BYTES);
  localparam int LW = $clog2(WINDOW_BYTES + 1);
  localparam int XW = ((LW > IDX_W) ? LW : IDX_W) + 1;
  localparam int P  = POSITION_BITS;
  localparam int BW = POSITION_BITS + 2;

  cfg_t cfg_r;
  logic [LW-1:0] len_eff;

  // shifted pattern: entry d is compared with the byte d places back
  logic [BYTE_W-1:0]       sh_pat_r [WINDOW_BYTES];
  logic [WINDOW_BYTES-1:0] sh_care_r;
  logic [WINDOW_BYTES-1:0] raw_care_r;
  logic [BYTE_W-1:0]       win_r [WINDOW_BYTES];
  logic [BYTE_W-1:0]       win_new [WINDOW_BYTES];
  logic [WINDOW_BYTES-1:0] eq;

  logic          sweep_r;
  logic [AW-1:0] sw_cnt_r;
  logic          sw_wr_v_r;
  logic [AW-1:0] sw_wr_idx_r;
  logic          sw_wr_care_r;
  logic [LW-1:0] sw_diff;
  logic [AW-1:0] sw_addr;
  logic          sw_in_range;
  logic          busy;
  logic [BYTE_W-1:0] ram_rdata;

  logic          ld;
  logic          ld_in;
  logic [XW-1:0] ld_diff;
  logic [AW-1:0] ld_pos;
  logic          is_data;

  logic [P-1:0]  seen_r;
  logic [P:0]    seen_inc;
  logic          sat;
  logic          short_c;

  logic                    s1_v_r;
  logic                    s1_eos_r;
  logic                    s1_skip_r;
  logic [P-1:0]            s1_pos_r;
  logic [WINDOW_BYTES-1:0] s1_eq_r;
  logic [BW-1:0]           base;
  logic                    base_ok;
  logic                    s1_hit;
  logic                    s1_res;
  logic                    s1_go;
  logic                    s1_free;
  logic                    out_free;
  logic [CNT_W-1:0]        cnt_r;
  logic                    out_v_r;
  res_t                    res_r;
  res_t                    res_nxt;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pattern_length <= LEN_W'(1);
      cfg_r.base_shift     <= '0;
      cfg_r.max_matches    <= CNT_W'(1);
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_PATTERN_LENGTH: cfg_r.pattern_length <= cfg_data;
        REG_BASE_SHIFT:     cfg_r.base_shift     <= cfg_data;
        REG_MAX_MATCHES:    cfg_r.max_matches    <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (cfg_r.pattern_length == '0) begin
      len_eff = LW'(1);
    end else if ((LW + LEN_W)'(cfg_r.pattern_length) > (LW + LEN_W)'(WINDOW_BYTES)) begin
      len_eff = LW'(WINDOW_BYTES);
    end else begin
      len_eff = LW'(cfg_r.pattern_length);
    end
  end

  // rebuild the shifted pattern after a length change, one entry a cycle
  assign sw_diff     = len_eff - LW'(1) - LW'(sw_cnt_r);
  assign sw_addr     = sw_diff[AW-1:0];
  assign sw_in_range = LW'(sw_cnt_r) < len_eff;
  assign busy        = sweep_r || sw_wr_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r   <= 1'b0;
      sw_cnt_r  <= '0;
      sw_wr_v_r <= 1'b0;
    end else begin
      sw_wr_v_r <= sweep_r;
      if (cfg_valid && cfg_index == REG_PATTERN_LENGTH) begin
        sweep_r  <= 1'b1;
        sw_cnt_r <= '0;
      end else if (sweep_r) begin
        sw_cnt_r <= sw_cnt_r + AW'(1);
        if (sw_cnt_r == AW'(WINDOW_BYTES - 1)) begin
          sweep_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    sw_wr_idx_r  <= sw_cnt_r;
    sw_wr_care_r <= sw_in_range && raw_care_r[sw_addr];
  end

  // front-to-back queue pop; loads need no downstream slot
  assign s1_free = !s1_v_r || s1_go;
  assign q_pop   = q_valid && !busy && (q_cmd.kind == CMD_LOAD || s1_free);
  assign ld      = q_pop && q_cmd.kind == CMD_LOAD;
  assign is_data = q_pop && q_cmd.kind == CMD_DATA;
  assign ld_in   = XW'(q_cmd.idx) < XW'(len_eff);
  assign ld_diff = XW'(len_eff) - XW'(1) - XW'(q_cmd.idx);
  assign ld_pos  = ld_diff[AW-1:0];

  msm_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(WINDOW_BYTES)
  ) u_pat_ram (
    .clk  (clk),
    .we   (ld),
    .waddr(AW'(q_cmd.idx)),
    .wdata(q_cmd.value),
    .raddr(sw_addr),
    .rdata(ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_care_r <= '0;
      sh_care_r  <= '0;
    end else begin
      if (ld) begin
        raw_care_r[AW'(q_cmd.idx)] <= q_cmd.care;
      end
      if (sw_wr_v_r) begin
        sh_care_r[sw_wr_idx_r] <= sw_wr_care_r;
      end else if (ld && ld_in) begin
        sh_care_r[ld_pos] <= q_cmd.care;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sw_wr_v_r) begin
      sh_pat_r[sw_wr_idx_r] <= ram_rdata;
    end else if (ld && ld_in) begin
      sh_pat_r[ld_pos] <= q_cmd.value;
    end
  end

  // window of recent bytes, newest at index 0
  always_comb begin
    win_new[0] = q_cmd.value;
    for (int d = 1; d < WINDOW_BYTES; d++) begin
      win_new[d] = win_r[d-1];
    end
    for (int d = 0; d < WINDOW_BYTES; d++) begin
      eq[d] = !sh_care_r[d] || (sh_pat_r[d] == win_new[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (is_data) begin
      win_r <= win_new;
    end
  end

  assign sat      = &seen_r;
  assign seen_inc = {1'b0, seen_r} + (P + 1)'(1);
  assign short_c  = seen_inc < (P + 1)'(len_eff);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= '0;
    end else if (q_pop && q_cmd.kind == CMD_EOS) begin
      seen_r <= '0;
    end else if (is_data && !sat) begin
      seen_r <= seen_inc[P-1:0];
    end
  end

  // stage 1: reduce compare, base position, result decision
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (s1_free) begin
      s1_v_r <= q_pop && q_cmd.kind != CMD_LOAD;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_free) begin
      s1_eos_r  <= q_cmd.kind == CMD_EOS;
      s1_skip_r <= sat || short_c;
      s1_pos_r  <= seen_r;
      s1_eq_r   <= eq;
    end
  end

  assign base = BW'(s1_pos_r) + BW'(1) - BW'(len_eff)
              - {{(BW - SHIFT_W){cfg_r.base_shift[SHIFT_W-1]}}, cfg_r.base_shift};
  assign base_ok = ~|base[BW-1:BW-2];

  assign s1_hit = s1_v_r && !s1_eos_r && !s1_skip_r && (cnt_r < cfg_r.max_matches)
               && (&s1_eq_r) && base_ok;
  assign s1_res   = s1_hit || (s1_v_r && s1_eos_r);
  assign out_free = !out_v_r || out_ready;
  assign s1_go    = s1_v_r && (!s1_res || out_free);

  always_comb begin
    res_nxt = '0;
    if (s1_eos_r) begin
      res_nxt.stream_done = 1'b1;
      res_nxt.match_count = cnt_r;
    end else begin
      res_nxt.match_found    = 1'b1;
      res_nxt.match_position = POS_OUT_W'(base[P-1:0]);
      res_nxt.match_number   = cnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r   <= '0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_go && s1_eos_r) begin
        cnt_r <= '0;
      end else if (s1_go && s1_hit) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end
      if (out_free) begin
        out_v_r <= s1_go && s1_res;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_free && s1_go && s1_res) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_v_r;
  assign out_res   = res_r;

  `MSM_ASSERT_IMP(a_no_pop_in_sweep, busy, !q_pop, "request popped during pattern rebuild")
  `MSM_ASSERT_NEXT(a_s1_holds, s1_v_r && !s1_go, s1_v_r && $stable(s1_pos_r), "stage 1 lost")
  `MSM_ASSERT_NEXT(a_hit_reaches_out, s1_go && s1_hit, out_v_r && res_r.match_found, "hit lost")

endmodule

// ===== rtl/masked_signature_stream_matcher.sv =====
// Masked byte-signature search over a byte stream. Pattern loads (tuser 0),
// data bytes (tuser 1) and end-of-stream requests (tuser 2) enter on in_;
// each data byte closes a window of pattern_length bytes that is compared
// against the loaded bytes wherever their care bit is set, and a hit reports
// the base position (window start minus base_shift) until max_matches hits
// are in; end of stream reports the count and restarts position counting.
// One request is taken per clock unless a pattern rebuild or a stalled output backs
// up the queue; a result passes the front register, a queue entry, the compare
// register and the output register before it is presented on out_.
// Writing pattern_length rebuilds the shifted pattern copy through the
// pattern memory's single read port, so queued requests wait until that
// rebuild is done before work resumes.
module masked_signature_stream_matcher import msm_pkg::*; #(
  parameter int WINDOW_BYTES  = WINDOW_BYTES_DEF,
  parameter int POSITION_BITS = POSITION_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [REG_IDX_W-1:0]   cfg_index,
  input  logic [LEN_W-1:0]       cfg_data,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // pattern_index[5:0], pattern_byte[13:6], pattern_care[14], data_byte[22:15], pad
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // func[1:0]
  input  logic [IN_TUSER_W-1:0]  in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // match_position[31:0], match_number[35:32], match_count[39:36]
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // match_found[0], stream_done[1]
  output logic [OUT_TUSER_W-1:0] out_tuser
);

  logic q_push_valid;
  logic q_push_ready;
  cmd_t q_push_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;
  res_t res;

  msm_front #(
    .WINDOW_BYTES(WINDOW_BYTES)
  ) u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_tvalid),
    .in_ready        (in_tready),
    .in_func         (in_tuser),
    .in_pattern_index(in_tdata[5:0]),
    .in_pattern_byte (in_tdata[13:6]),
    .in_pattern_care (in_tdata[14]),
    .in_data_byte    (in_tdata[22:15]),
    .push_valid      (q_push_valid),
    .push_ready      (q_push_ready),
    .push_cmd        (q_push_cmd)
  );

  msm_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push_valid(q_push_valid),
    .push_ready(q_push_ready),
    .push_cmd  (q_push_cmd),
    .pop_valid (q_valid),
    .pop       (q_pop),
    .pop_cmd   (q_cmd)
  );

  msm_back #(
    .WINDOW_BYTES (WINDOW_BYTES),
    .POSITION_BITS(POSITION_BITS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_valid  (q_valid),
    .q_cmd    (q_cmd),
    .q_pop    (q_pop),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .out_res  (res)
  );

  assign out_tdata = {res.match_count, res.match_number, res.match_position};
  assign out_tuser = {res.stream_done, res.match_found};

endmodule

// ===== sim/tb_masked_signature_stream_matcher.sv =====
module tb_masked_signature_stream_matcher;
  import msm_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NOP = 2'd3;  // unused code, block drops it
  // long enough for a pattern rebuild plus the pipe to drain
  localparam int SETTLE_CYCLES = WINDOW_BYTES_DEF + 16;
  localparam int RANDOM_ITEMS = 850;
  localparam int REPORT_CAP = 40;

  typedef enum logic [1:0] {
    CHK_MODEL,  // expectation from the predictor
    CHK_NONE,   // no result expected
    CHK_RES     // result typed into the table
  } chk_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [IDX_W-1:0]  idx;
    logic [BYTE_W-1:0] pbyte;
    logic              care;
    logic [BYTE_W-1:0] dbyte;
  } stim_t;

  typedef struct packed {
    stim_t s;
    chk_t  chk;
    res_t  want;
  } row_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [REG_IDX_W-1:0]   cfg_index = '0;
  logic [LEN_W-1:0]       cfg_data = '0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [IN_TUSER_W-1:0]  in_tuser = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  masked_signature_stream_matcher dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #5 clk = ~clk;

  // predictor state
  logic [BYTE_W-1:0] sig_mem  [WINDOW_BYTES_DEF];
  logic              sig_care [WINDOW_BYTES_DEF];
  logic [BYTE_W-1:0] hist     [WINDOW_BYTES_DEF];  // [0] newest byte
  logic [31:0]       pos_cnt;
  logic [CNT_W-1:0]  hit_cnt;
  logic [LEN_W-1:0]  reg_len;
  logic [SHIFT_W-1:0] reg_shift;
  logic [CNT_W-1:0]  reg_max;

  res_t pending_reports[$];
  int   mismatch_count = 0;
  int   fed_items = 0;
  bit   offering = 0;
  bit   no_gaps = 0;
  int   burst_left = 0;

  // receiver pacing
  int          hold_req = 0;
  int          hold_left = 0;
  int          rx_mode = 0;
  int          rx_left = 0;
  int unsigned rx_cyc = 0;

  row_t dir_tab [18];

  task automatic flag_mismatch(input string what, input longint unsigned got_v,
                               input longint unsigned want_v);
    if (mismatch_count < REPORT_CAP)
      $display("%0t: %s got 0x%0h want 0x%0h", $time, what, got_v, want_v);
    mismatch_count++;
  endtask

  task automatic scan_predict(input stim_t s, output bit has, output res_t r);
    int unsigned span;
    logic [31:0] pos;
    longint      base;
    bit          ok;
    r = '0;
    has = 0;
    case (s.func)
      FUNC_LOAD: begin
        sig_mem[s.idx] = s.pbyte;
        sig_care[s.idx] = s.care;
      end
      FUNC_EOS: begin
        has = 1;
        r.stream_done = 1'b1;
        r.match_count = hit_cnt;
        foreach (hist[i]) hist[i] = '0;
        pos_cnt = '0;
        hit_cnt = '0;
      end
      FUNC_DATA: begin
        span = (reg_len == 0) ? 1 : (reg_len > WINDOW_BYTES_DEF) ? WINDOW_BYTES_DEF : reg_len;
        pos = pos_cnt;
        for (int i = WINDOW_BYTES_DEF - 1; i > 0; i--) hist[i] = hist[i-1];
        hist[0] = s.dbyte;
        // saturated position: byte still shifts in, count frozen, no report
        ok = (pos != '1);
        if (ok) pos_cnt = pos + 32'd1;
        if (hit_cnt >= reg_max) ok = 0;
        if (longint'(pos) + 1 < longint'(span)) ok = 0;
        for (int i = 0; i < span; i++)
          if (sig_care[i] && sig_mem[i] != hist[span-1-i]) ok = 0;
        base = longint'(pos) + 1 - longint'(span) - longint'($signed(reg_shift));
        if (ok && base >= 0 && base <= longint'(32'hFFFF_FFFF)) begin
          has = 1;
          r.match_found = 1'b1;
          r.match_position = base[31:0];
          r.match_number = hit_cnt;
          hit_cnt = hit_cnt + 4'd1;
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_report();
    res_t got;
    res_t want;
    got.match_found    = out_tuser[0];
    got.stream_done    = out_tuser[1];
    got.match_position = out_tdata[31:0];
    got.match_number   = out_tdata[35:32];
    got.match_count    = out_tdata[39:36];
    if (pending_reports.size() == 0) begin
      flag_mismatch("result with none pending, tdata", out_tdata, 0);
      return;
    end
    want = pending_reports.pop_front();
    if (got.match_found != want.match_found)
      flag_mismatch("match_found", got.match_found, want.match_found);
    if (got.match_position != want.match_position)
      flag_mismatch("match_position", got.match_position, want.match_position);
    if (got.match_number != want.match_number)
      flag_mismatch("match_number", got.match_number, want.match_number);
    if (got.stream_done != want.stream_done)
      flag_mismatch("stream_done", got.stream_done, want.stream_done);
    if (got.match_count != want.match_count)
      flag_mismatch("match_count", got.match_count, want.match_count);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) check_report();
  end

  always @(posedge clk) begin
    rx_cyc++;
    if (hold_left > 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else if (hold_req > 0) begin
      // long hold-off so the pipe fills and backs up the input
      hold_left = hold_req - 1;
      hold_req = 0;
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(8, 120);
      end else begin
        rx_left--;
      end
      case (rx_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= 1'($urandom_range(0, 1));
        2: out_tready <= ($urandom_range(0, 3) == 0);
        default: out_tready <= ((rx_cyc % 5) < 3);
      endcase
    end
  end

  function automatic stim_t rand_stim();
    stim_t v;
    v.func  = 2'($urandom_range(0, 3));
    v.idx   = 6'($urandom_range(0, 63));
    v.pbyte = 8'($urandom_range(0, 255));
    v.care  = 1'($urandom_range(0, 1));
    v.dbyte = 8'($urandom_range(0, 255));
    return v;
  endfunction

  task automatic park_input();
    if (offering) begin
      in_tvalid <= 1'b0;
      offering = 0;
    end
  endtask

  task automatic offer_item(input stim_t s, input chk_t chk, input res_t want);
    bit   has;
    res_t r;
    in_tvalid <= 1'b1;
    offering = 1;
    in_tdata <= {1'b0, s.dbyte, s.care, s.pbyte, s.idx};
    in_tuser <= s.func;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    scan_predict(s, has, r);
    case (chk)
      CHK_MODEL: if (has) pending_reports.push_back(r);
      CHK_RES:   pending_reports.push_back(want);
      default: ;
    endcase
    if (s.func != FUNC_NOP) fed_items++;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        park_input();
        repeat ($urandom_range(1, 6)) @(posedge clk);
        burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                 : $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // wait out every pending report, a pattern rebuild and the pipe depth
  // before touching registers
  task automatic settle();
    park_input();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [LEN_W-1:0] len_v, input logic [LEN_W-1:0] shift_v,
                          input logic [LEN_W-1:0] max_v);
    logic [REG_IDX_W-1:0] ids  [3];
    logic [LEN_W-1:0]     vals [3];
    ids  = '{REG_PATTERN_LENGTH, REG_BASE_SHIFT, REG_MAX_MATCHES};
    vals = '{len_v, shift_v, max_v};
    for (int k = 0; k < 3; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= ids[k];
      cfg_data <= vals[k];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (ids[k])
        REG_PATTERN_LENGTH: reg_len = vals[k];
        REG_BASE_SHIFT:     reg_shift = vals[k];
        REG_MAX_MATCHES:    reg_max = vals[k][CNT_W-1:0];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic run_scan_phase(input int ph);
    logic [LEN_W-1:0]  len_v;
    logic [LEN_W-1:0]  shift_v;
    logic [LEN_W-1:0]  max_v;
    logic [BYTE_W-1:0] sig  [WINDOW_BYTES_DEF];
    bit                sig_c [WINDOW_BYTES_DEF];
    int unsigned       span;
    int unsigned       nbytes;
    int unsigned       sent;
    int unsigned       flip;
    int unsigned       k;
    stim_t             s;
    settle();
    case (ph)
      0: begin len_v = 7'd0;   shift_v = 7'd0;   max_v = 7'd15;  end  // zero length acts as one
      1: begin len_v = 7'd127; shift_v = 7'h40;  max_v = 7'd15;  end  // clipped to window, shift -64
      2: begin len_v = 7'd64;  shift_v = 7'h3F;  max_v = 7'd15;  end
      3: begin len_v = 7'd4;   shift_v = 7'd0;   max_v = 7'h70;  end  // max_matches reads as zero
      4: begin len_v = 7'd2;   shift_v = 7'h3F;  max_v = 7'd15;  end  // early bases negative
      default: begin
        k = $urandom_range(0, 9);
        len_v = (k < 7) ? 7'($urandom_range(1, 8)) :
                (k < 9) ? 7'($urandom_range(9, 24)) : 7'($urandom_range(25, 127));
        shift_v = ($urandom_range(0, 1) == 1) ? 7'($urandom_range(0, 127))
                                              : 7'($urandom_range(0, 8)) - 7'd4;
        max_v = 7'($urandom_range(0, 7)) << 4;
        if ($urandom_range(0, 19) != 0) max_v = max_v | 7'($urandom_range(1, 15));
      end
    endcase
    set_regs(len_v, shift_v, max_v);
    span = (len_v == 0) ? 1 : (len_v > WINDOW_BYTES_DEF) ? WINDOW_BYTES_DEF : len_v;

    // stray loads anywhere in the window, then the signature proper
    repeat ($urandom_range(0, 2)) begin
      s = rand_stim();
      s.func = FUNC_LOAD;
      offer_item(s, CHK_MODEL, '0);
    end
    for (int j = 0; j < span; j++) begin
      s = rand_stim();
      s.func = FUNC_LOAD;
      s.idx = 6'(j);
      s.care = ($urandom_range(0, 9) < 7);
      sig[j] = s.pbyte;
      sig_c[j] = s.care;
      offer_item(s, CHK_MODEL, '0);
    end

    if (ph == 5 || (ph > 5 && $urandom_range(0, 11) == 0)) begin
      hold_req = $urandom_range(200, 400);
      no_gaps = 1;
    end

    nbytes = $urandom_range(span, 2 * span + 40);
    sent = 0;
    while (sent < nbytes) begin
      k = $urandom_range(0, 99);
      if (k < 45) begin
        flip = ($urandom_range(0, 7) == 0) ? $urandom_range(0, span - 1) : span;
        for (int j = 0; j < span; j++) begin
          s = rand_stim();
          s.func = FUNC_DATA;
          if (sig_c[j]) s.dbyte = sig[j];
          if (j == flip) s.dbyte = ~sig[j];
          offer_item(s, CHK_MODEL, '0);
        end
        sent += span;
      end else if (k < 95) begin
        s = rand_stim();
        s.func = FUNC_DATA;
        if ($urandom_range(0, 1) == 1) s.dbyte = sig[$urandom_range(0, span - 1)];
        offer_item(s, CHK_MODEL, '0);
        sent++;
      end else if (k < 98) begin
        s = rand_stim();
        s.func = FUNC_NOP;
        offer_item(s, CHK_MODEL, '0);
      end else begin
        // pattern rewrite in mid-stream
        s = rand_stim();
        s.func = FUNC_LOAD;
        if (s.idx < span) begin
          sig[s.idx] = s.pbyte;
          sig_c[s.idx] = s.care;
        end
        offer_item(s, CHK_MODEL, '0);
      end
    end
    no_gaps = 0;

    if ($urandom_range(0, 9) != 0) begin
      s = rand_stim();
      s.func = FUNC_EOS;
      offer_item(s, CHK_MODEL, '0);
    end
  endtask

  initial begin
    #4_000_000;
    $display("masked_signature_stream_matcher verification failed");
    $finish;
  end

  initial begin
    int ph;
    foreach (hist[i]) begin
      hist[i] = '0;
      sig_mem[i] = '0;
      sig_care[i] = 1'b0;
    end
    pos_cnt = '0;
    hit_cnt = '0;
    reg_len = 7'd1;
    reg_shift = '0;
    reg_max = 4'd1;

    // reset settings: length 1, shift 0, one match per stream
    dir_tab = '{
      '{'{FUNC_EOS,  6'd0,  8'h00, 1'b0, 8'h00}, CHK_RES,  '{1'b0, 32'd0, 4'd0, 1'b1, 4'd0}},
      '{'{FUNC_DATA, 6'd0,  8'h00, 1'b0, 8'h00}, CHK_RES,  '{1'b1, 32'd0, 4'd0, 1'b0, 4'd0}},
      '{'{FUNC_DATA, 6'd63, 8'hFF, 1'b1, 8'hFF}, CHK_NONE, '0},
      '{'{FUNC_EOS,  6'd63, 8'hFF, 1'b1, 8'hFF}, CHK_RES,  '{1'b0, 32'd0, 4'd0, 1'b1, 4'd1}},
      '{'{FUNC_NOP,  6'd63, 8'hFF, 1'b1, 8'hFF}, CHK_NONE, '0},
      '{'{FUNC_LOAD, 6'd0,  8'hFF, 1'b1, 8'h00}, CHK_NONE, '0},
      '{'{FUNC_LOAD, 6'd63, 8'h00, 1'b1, 8'hFF}, CHK_NONE, '0},
      '{'{FUNC_DATA, 6'd0,  8'h00, 1'b0, 8'h00}, CHK_NONE, '0},
      '{'{FUNC_DATA, 6'd0,  8'h00, 1'b0, 8'hFF}, CHK_RES,  '{1'b1, 32'd1, 4'd0, 1'b0, 4'd0}},
      '{'{FUNC_DATA, 6'd0,  8'h00, 1'b0, 8'hFF}, CHK_NONE, '0},
      '{'{FUNC_EOS,  6'd0,  8'h00, 1'b0, 8'h00}, CHK_RES,  '{1'b0, 32'd0, 4'd0, 1'b1, 4'd1}},
      '{'{FUNC_LOAD, 6'd0,  8'h00, 1'b1, 8'hFF}, CHK_NONE, '0},
      '{'{FUNC_DATA, 6'd0,  8'h00, 1'b0, 8'hFF}, CHK_NONE, '0},
      '{'{FUNC_DATA, 6'd0,  8'h00, 1'b0, 8'h00}, CHK_RES,  '{1'b1, 32'd1, 4'd0, 1'b0, 4'd0}},
      '{'{FUNC_EOS,  6'd0,  8'h00, 1'b0, 8'h00}, CHK_RES,  '{1'b0, 32'd0, 4'd0, 1'b1, 4'd1}},
      '{'{FUNC_LOAD, 6'd0,  8'h5A, 1'b0, 8'h00}, CHK_NONE, '0},
      '{'{FUNC_DATA, 6'd0,  8'h00, 1'b0, 8'hA5}, CHK_RES,  '{1'b1, 32'd0, 4'd0, 1'b0, 4'd0}},
      '{'{FUNC_EOS,  6'd0,  8'h00, 1'b0, 8'h00}, CHK_RES,  '{1'b0, 32'd0, 4'd0, 1'b1, 4'd1}}
    };

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) offer_item(dir_tab[i].s, dir_tab[i].chk, dir_tab[i].want);

    fed_items = 0;
    ph = 0;
    while (fed_items < RANDOM_ITEMS) begin
      run_scan_phase(ph);
      ph++;
    end

    park_input();
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES * 2) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("masked_signature_stream_matcher verification clean");
    end else begin
      $display("masked_signature_stream_matcher verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/msm_pkg.sv
rtl/msm_ram.sv
rtl/msm_front.sv
rtl/msm_queue.sv
rtl/msm_back.sv
rtl/masked_signature_stream_matcher.sv
sim/tb_masked_signature_stream_matcher.sv
